### sv/peak_window_rate_finder_unit_assert.svh
// Assertion macros shared by the peak window rate finder RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef PEAK_WINDOW_RATE_FINDER_UNIT_ASSERT_SVH
`define PEAK_WINDOW_RATE_FINDER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PWRF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PWRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/pwrf_pkg.sv
// Package for the peak window rate finder: widths, defaults and shared types.
// No dependencies.
package pwrf_pkg;

    localparam int WINDOW_MAX_DEF = 256;
    localparam int COUNT_BITS_DEF = 24;

    localparam int OFFSET_W = 32;
    localparam int WIN_W    = 9;
    localparam int START_W  = 24;
    localparam logic [WIN_W-1:0] WIN_RESET = 9'd30;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic                last;
        logic                even;
    } item_t;

    typedef struct packed {
        logic                start;
        logic [OFFSET_W-1:0] dividend;
        logic [OFFSET_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [OFFSET_W-1:0] quotient;
        logic [OFFSET_W-1:0] remainder;
    } div_rsp_t;

endpackage

### sv/pwrf_front.sv
// Input side: accepts offset transactions, tags them and queues them.
// Depends on pwrf_pkg.
module pwrf_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pwrf_pkg::OFFSET_W-1:0] s_tdata,
    input  logic                          s_tlast,
    output logic                          q_valid,
    output pwrf_pkg::item_t               q_item,
    input  logic                          q_pop
);

    localparam int DEPTH = pwrf_pkg::QUEUE_DEPTH;
    localparam int PW    = pwrf_pkg::QPTR_W;

    pwrf_pkg::item_t  entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             push;
    pwrf_pkg::item_t  tagged_item;

    assign s_tready = (count_reg != (PW+1)'(DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        tagged_item.offset = s_tdata;
        tagged_item.last   = s_tlast;
        tagged_item.even   = ~s_tdata[0];
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + PW'(1);
        end
        if (q_pop)
        begin
            rd_ptr_next = rd_ptr_reg + PW'(1);
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + (PW+1)'(1);
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= tagged_item;
        end
    end

endmodule

### sv/pwrf_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on pwrf_pkg. Divisor must be nonzero.
module pwrf_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  pwrf_pkg::div_req_t  req,
    output pwrf_pkg::div_rsp_t  rsp
);

    localparam int DW    = pwrf_pkg::OFFSET_W;
    localparam int CNT_W = $clog2(DW);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    dvs_reg, dvs_next;
    logic [DW:0]      trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DW'(trial - {1'b0, dvs_reg}) : trial[DW-1:0];
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

### sv/pwrf_back.sv
// Execution side: ring buffer, window search, stream state and result register.
// Depends on pwrf_pkg, the assertion macros and pwrf_divider (via request/response).
`include "peak_window_rate_finder_unit_assert.svh"
module pwrf_back #(
    parameter int WINDOW_MAX = pwrf_pkg::WINDOW_MAX_DEF,
    parameter int COUNT_BITS = pwrf_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [pwrf_pkg::WIN_W-1:0]    cfg_wr_data,
    input  logic                          q_valid,
    input  pwrf_pkg::item_t               q_item,
    output logic                          q_pop,
    output pwrf_pkg::div_req_t            div_req,
    input  pwrf_pkg::div_rsp_t            div_rsp,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pwrf_pkg::OFFSET_W-1:0] out_rate,
    output logic [pwrf_pkg::START_W-1:0]  out_start,
    output logic                          out_odd,
    output logic                          out_ovf
);

    localparam int OW     = pwrf_pkg::OFFSET_W;
    localparam int WW     = pwrf_pkg::WIN_W;
    localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SW     = (SLOT_W + 1 > WW) ? SLOT_W + 1 : WW;
    localparam int CW     = (COUNT_BITS > WW) ? COUNT_BITS : WW;

    localparam logic [1:0] ST_RUN = 2'd0;
    localparam logic [1:0] ST_MOD = 2'd1;
    localparam logic [1:0] ST_DIV = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [WW-1:0]         window_reg, window_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic                  dirty_reg, dirty_next;
    logic [COUNT_BITS-1:0] item_count_reg, item_count_next;
    logic [OW-1:0]         first_offset_reg, first_offset_next;
    logic [OW-1:0]         best_diff_reg, best_diff_next;
    logic [COUNT_BITS-1:0] best_index_reg, best_index_next;
    logic                  odd_so_far_reg, odd_so_far_next;
    logic                  count_ovf_reg, count_ovf_next;

    logic                  stb_valid_reg, stb_valid_next;
    logic                  stb_cmp_reg;
    logic [OW-1:0]         stb_off_reg;
    logic [COUNT_BITS-1:0] stb_idx_reg;
    logic [OW-1:0]         mem_rd_reg;
    logic [OW-1:0]         ring [WINDOW_MAX];

    logic                  out_valid_reg, out_valid_next;
    logic [OW-1:0]         out_rate_reg, out_rate_next;
    logic [pwrf_pkg::START_W-1:0] out_start_reg, out_start_next;
    logic                  out_odd_reg, out_odd_next;
    logic                  out_ovf_reg, out_ovf_next;

    logic                  win_ok;
    logic                  cnt_sat;
    logic                  cnt_ge_w;
    logic                  slot_wrap;
    logic                  slot_lt_w;
    logic                  frame_pop;
    logic                  mod_start;
    logic                  last_pop;
    logic                  mem_en;
    logic [OW-1:0]         diff;
    logic                  better;
    logic [OW-1:0]         first_sel;
    logic [OW-1:0]         fb_span;
    logic [OW-1:0]         fb_prod;

    assign win_ok    = (window_reg != '0) && (32'(window_reg) <= 32'(WINDOW_MAX));
    assign cnt_sat   = &item_count_reg;
    assign cnt_ge_w  = (CW'(item_count_reg) >= CW'(window_reg));
    assign slot_wrap = ((SW'(slot_reg) + SW'(1)) == SW'(window_reg));
    assign slot_lt_w = (SW'(slot_reg) < SW'(window_reg));

    assign frame_pop = (state_reg == ST_RUN) && q_valid && !q_item.last
                       && !(dirty_reg && win_ok && !cnt_sat);
    assign mod_start = (state_reg == ST_RUN) && q_valid && !q_item.last
                       && dirty_reg && win_ok && !cnt_sat;
    assign last_pop  = (state_reg == ST_RUN) && q_valid && q_item.last
                       && !stb_valid_reg && !out_valid_reg;
    assign q_pop     = frame_pop || last_pop;
    assign mem_en    = frame_pop && !cnt_sat && win_ok;

    assign diff      = stb_off_reg - mem_rd_reg;
    assign better    = stb_valid_reg && stb_cmp_reg && (diff > best_diff_reg);

    assign first_sel = (item_count_reg != '0) ? first_offset_reg : q_item.offset;
    assign fb_span   = q_item.offset - first_sel;
    assign fb_prod   = fb_span * OW'(window_reg);

    always_comb
    begin
        state_next        = state_reg;
        window_next       = window_reg;
        slot_next         = slot_reg;
        dirty_next        = dirty_reg;
        item_count_next   = item_count_reg;
        first_offset_next = first_offset_reg;
        best_diff_next    = best_diff_reg;
        best_index_next   = best_index_reg;
        odd_so_far_next   = odd_so_far_reg;
        count_ovf_next    = count_ovf_reg;
        stb_valid_next    = mem_en;
        out_valid_next    = out_valid_reg;
        out_rate_next     = out_rate_reg;
        out_start_next    = out_start_reg;
        out_odd_next      = out_odd_reg;
        out_ovf_next      = out_ovf_reg;
        div_req.start     = 1'b0;
        div_req.dividend  = OW'(item_count_reg);
        div_req.divisor   = OW'(window_reg);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (better)
        begin
            best_diff_next  = diff;
            best_index_next = stb_idx_reg;
        end

        case (state_reg)
            ST_RUN:
            begin
                if (mod_start)
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_MOD;
                end
                else if (frame_pop)
                begin
                    if (item_count_reg == '0)
                    begin
                        first_offset_next = q_item.offset;
                    end
                    if (q_item.even)
                    begin
                        odd_so_far_next = 1'b0;
                    end
                    if (cnt_sat)
                    begin
                        count_ovf_next = 1'b1;
                    end
                    else
                    begin
                        item_count_next = item_count_reg + COUNT_BITS'(1);
                        if (win_ok)
                        begin
                            slot_next = slot_wrap ? '0 : slot_reg + SLOT_W'(1);
                        end
                        else
                        begin
                            dirty_next = 1'b1;
                        end
                    end
                end
                else if (last_pop)
                begin
                    out_start_next = pwrf_pkg::START_W'(best_index_reg);
                    out_odd_next   = odd_so_far_reg;
                    out_ovf_next   = count_ovf_reg;
                    if (CW'(window_reg) < CW'(item_count_reg) && best_diff_reg != '0)
                    begin
                        out_rate_next  = best_diff_reg;
                        out_valid_next = 1'b1;
                    end
                    else if (item_count_reg == '0)
                    begin
                        out_rate_next  = '0;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = fb_prod;
                        div_req.divisor  = OW'(item_count_reg);
                        state_next       = ST_DIV;
                    end
                    slot_next         = '0;
                    dirty_next        = 1'b0;
                    item_count_next   = '0;
                    first_offset_next = '0;
                    best_diff_next    = '0;
                    best_index_next   = '0;
                    odd_so_far_next   = 1'b1;
                    count_ovf_next    = 1'b0;
                end
            end
            ST_MOD:
            begin
                if (div_rsp.done)
                begin
                    slot_next  = SLOT_W'(div_rsp.remainder);
                    dirty_next = 1'b0;
                    state_next = ST_RUN;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    out_rate_next  = div_rsp.quotient;
                    out_valid_next = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        if (cfg_wr_en)
        begin
            window_next = cfg_wr_data;
            dirty_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_RUN;
            window_reg       <= pwrf_pkg::WIN_RESET;
            slot_reg         <= '0;
            dirty_reg        <= 1'b0;
            item_count_reg   <= '0;
            first_offset_reg <= '0;
            best_diff_reg    <= '0;
            best_index_reg   <= '0;
            odd_so_far_reg   <= 1'b1;
            count_ovf_reg    <= 1'b0;
            stb_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            window_reg       <= window_next;
            slot_reg         <= slot_next;
            dirty_reg        <= dirty_next;
            item_count_reg   <= item_count_next;
            first_offset_reg <= first_offset_next;
            best_diff_reg    <= best_diff_next;
            best_index_reg   <= best_index_next;
            odd_so_far_reg   <= odd_so_far_next;
            count_ovf_reg    <= count_ovf_next;
            stb_valid_reg    <= stb_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rate_reg  <= out_rate_next;
        out_start_reg <= out_start_next;
        out_odd_reg   <= out_odd_next;
        out_ovf_reg   <= out_ovf_next;
        if (mem_en)
        begin
            stb_off_reg <= q_item.offset;
            stb_cmp_reg <= cnt_ge_w;
            stb_idx_reg <= COUNT_BITS'(CW'(item_count_reg) - CW'(window_reg));
        end
    end

    // ring: read-before-write on the same slot
    always_ff @(posedge clk)
    begin
        if (mem_en)
        begin
            mem_rd_reg     <= ring[slot_reg];
            ring[slot_reg] <= q_item.offset;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rate  = out_rate_reg;
    assign out_start = out_start_reg;
    assign out_odd   = out_odd_reg;
    assign out_ovf   = out_ovf_reg;

    `PWRF_ASSERT_NOW(a_last_drained, clk, rst_n, last_pop, !stb_valid_reg && !out_valid_reg, "last transaction taken before window pipeline drained")
    `PWRF_ASSERT_NOW(a_no_pop_busy, clk, rst_n, state_reg != ST_RUN, !q_pop, "queue popped while divider busy")
    `PWRF_ASSERT_NOW(a_slot_range, clk, rst_n, !dirty_reg && win_ok, slot_lt_w, "ring slot outside window")
    `PWRF_ASSERT_NEXT(a_div_owner, clk, rst_n, div_req.start, state_reg != ST_RUN, "divider started without waiting state")

endmodule

### sv/peak_window_rate_finder_unit.sv
// Peak window rate finder top level: queue front end, execution back end, divider.
// Depends on pwrf_pkg, pwrf_front, pwrf_back, pwrf_divider.
//
// Input stream (s_*): one cumulative 32-bit offset per transaction, tlast on the
// closing table entry. One result transaction (m_*) is produced per tlast.
// cfg_wr_en/cfg_wr_data load the window length; the user must write it only
// while the block is idle, which the block itself does not enforce. Throughput:
// one offset per cycle while no divider run is pending; the ring buffer is read
// and written once per offset, and the difference is compared in the next cycle.
// m_tvalid rises in the cycle after the closing entry is accepted when the window
// peak is used (acceptance waits for a pending compare), and after the divider run
// when the averaged value is needed. After a window write to a length within the
// ring, the next offset waits while the divider recomputes the ring slot.
// A four-entry queue decouples input from execution; s_tready drops only when
// it is full. Results sit in an output register; while m_tready is low the
// block keeps taking offsets, and the next closing entry waits for the register.
// Reset: window 30, stream state cleared, ring contents undefined until written.
module peak_window_rate_finder_unit #(
    parameter int WINDOW_MAX = pwrf_pkg::WINDOW_MAX_DEF,
    parameter int COUNT_BITS = pwrf_pkg::COUNT_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [31:0]                s_tdata,     // [31:0] offset
    input  logic                       s_tlast,     // is_last
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [55:0]                m_tdata,     // [31:0] peak_rate, [55:32] peak_start
    output logic [1:0]                 m_tuser,     // [0] all_odd, [1] overflow
    input  logic                       cfg_wr_en,
    input  logic [pwrf_pkg::WIN_W-1:0] cfg_wr_data
);

    logic                          q_valid;
    logic                          q_pop;
    pwrf_pkg::item_t               q_item;
    pwrf_pkg::div_req_t            div_req;
    pwrf_pkg::div_rsp_t            div_rsp;
    logic [pwrf_pkg::OFFSET_W-1:0] out_rate;
    logic [pwrf_pkg::START_W-1:0]  out_start;
    logic                          out_odd;
    logic                          out_ovf;

    pwrf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    pwrf_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    pwrf_back #(
        .WINDOW_MAX (WINDOW_MAX),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .div_req     (div_req),
        .div_rsp     (div_rsp),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_rate    (out_rate),
        .out_start   (out_start),
        .out_odd     (out_odd),
        .out_ovf     (out_ovf)
    );

    assign m_tdata = {out_start, out_rate};
    assign m_tuser = {out_ovf, out_odd};

endmodule
